### src/sts_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sts_pkg
// Shared types and constants for the sorted two-key table search block.
// ============================================================================
package sts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W       = 11;
    localparam int KEY_W       = 24;
    localparam int DATA_W      = 48;

    // func codes of an input transaction
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    // command codes carried through the queue
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  type_id;
        logic [15:0] resource_id;
        logic [23:0] data_offset;
        logic [23:0] data_length;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [10:0] position;
        logic [23:0] hit_offset;
        logic [23:0] hit_length;
        logic        overflow;
    } t_out;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } t_cmd;

endpackage

### src/sorted_table_binary_search_top.sv
`timescale 1ns / 1ps
// ============================================================================
// sorted_table_binary_search_top
// Sorted two-key resource table with load, clear and binary search.
// ============================================================================
// Every input transaction gives exactly one result transaction, in order.
// A search runs a binary search over the loaded entries, one probe per
// cycle into the key RAM, whose registered read feeds the compare and the
// next probe address. A two-entry queue lets the next transactions be
// accepted while one is at work; the table starts empty after reset.
module sorted_table_binary_search_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sts_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sts_pkg::t_out o_out_data
);

    logic                      w_q_valid;
    sts_pkg::t_cmd             w_q_item;
    logic                      w_q_pop;
    logic [sts_pkg::CNT_W-1:0] w_count;

    sts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (i_in_data),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    sts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_count     (w_count)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_count) <= 32'(sts_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |->
            (32'(o_out_data.position) < 32'(w_count)))
        else $error("hit position outside loaded entries");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

### src/sts_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// sts_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/sts_front.sv
`timescale 1ns / 1ps
// ============================================================================
// sts_front
// Accepts input transactions, classifies func into a command and holds the
// commands in a two-entry queue for the back end.
// ============================================================================
module sts_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sts_pkg::t_in  i_item,
    output logic          o_q_valid,
    output sts_pkg::t_cmd o_q_item,
    input  logic          i_q_pop
);

    sts_pkg::t_cmd r_slot [0:1];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    sts_pkg::t_cmd w_cmd;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_cmd.key  = {i_item.type_id, i_item.resource_id};
        w_cmd.data = {i_item.data_offset, i_item.data_length};
        case (i_item.func)
            sts_pkg::FUNC_LOAD:   w_cmd.cmd = sts_pkg::CMD_LOAD;
            sts_pkg::FUNC_CLEAR:  w_cmd.cmd = sts_pkg::CMD_CLEAR;
            sts_pkg::FUNC_SEARCH: w_cmd.cmd = sts_pkg::CMD_SEARCH;
            default:              w_cmd.cmd = sts_pkg::CMD_NOP;
        endcase
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_slot[r_rptr];
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_q_pop && o_q_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= w_cmd;
        end
    end

endmodule

### src/sts_back.sv
`timescale 1ns / 1ps
// ============================================================================
// sts_back
// Executes queued commands: loads into the key and data RAMs, clears the
// table, answers unused codes with an all-zero result and runs the binary
// search, one probe per cycle, into the output register.
// ============================================================================
module sts_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  sts_pkg::t_cmd         i_q_item,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sts_pkg::t_out         o_out_data,
    output logic [sts_pkg::CNT_W-1:0] o_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam int CW = sts_pkg::CNT_W;
    localparam int AW = sts_pkg::ADDR_W;

    logic [1:0]                 r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_lo, n_lo;
    logic [CW-1:0]              r_hi, n_hi;
    logic [CW-1:0]              r_mid, n_mid;
    logic [sts_pkg::KEY_W-1:0]  r_key, n_key;
    sts_pkg::t_out              r_res, n_res;
    logic                       r_out_valid, n_out_valid;
    sts_pkg::t_out              r_out, n_out;

    logic [sts_pkg::KEY_W-1:0]  w_key_rd;
    logic [sts_pkg::DATA_W-1:0] w_data_rd;
    logic                       w_we;
    logic [AW-1:0]              w_raddr;
    logic                       w_out_free;
    logic                       w_lt, w_gt;
    logic [CW-1:0]              w_nlo, w_nhi, w_nmid, w_imid;
    logic [CW:0]                w_sum;

    sts_ram #(.WIDTH(sts_pkg::KEY_W), .DEPTH(sts_pkg::TABLE_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_q_item.key),
        .i_raddr (w_raddr),
        .o_rdata (w_key_rd)
    );

    sts_ram #(.WIDTH(sts_pkg::DATA_W), .DEPTH(sts_pkg::TABLE_DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_q_item.data),
        .i_raddr (w_raddr),
        .o_rdata (w_data_rd)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_lt       = r_key < w_key_rd;
    assign w_gt       = r_key > w_key_rd;
    assign w_nlo      = w_gt ? (r_mid + CW'(1)) : r_lo;
    assign w_nhi      = w_lt ? r_mid : r_hi;
    assign w_sum      = {1'b0, w_nlo} + {1'b0, w_nhi};
    assign w_nmid     = w_sum[CW:1];
    assign w_imid     = r_count >> 1;
    assign w_raddr    = (r_state == S_IDLE) ? w_imid[AW-1:0] : w_nmid[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_item.cmd)
                        sts_pkg::CMD_SEARCH: begin
                            o_q_pop = 1'b1;
                            n_key   = i_q_item.key;
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_mid   = w_imid;
                            if (r_count == '0) begin
                                n_res   = '0;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_CMP;
                            end
                        end
                        sts_pkg::CMD_LOAD: begin
                            if (w_out_free) begin
                                o_q_pop        = 1'b1;
                                n_out_valid    = 1'b1;
                                n_out          = '0;
                                n_out.position = sts_pkg::t_pos'(r_count);
                                if (r_count == CW'(sts_pkg::TABLE_DEPTH)) begin
                                    n_out.overflow = 1'b1;
                                end else begin
                                    w_we    = 1'b1;
                                    n_count = r_count + CW'(1);
                                end
                            end
                        end
                        sts_pkg::CMD_CLEAR: begin
                            if (w_out_free) begin
                                o_q_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_count     = '0;
                            end
                        end
                        default: begin
                            if (w_out_free) begin
                                o_q_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = '0;
                            end
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (!w_lt && !w_gt) begin
                    n_res            = '0;
                    n_res.found      = 1'b1;
                    n_res.position   = sts_pkg::t_pos'(r_mid);
                    n_res.hit_offset = w_data_rd[47:24];
                    n_res.hit_length = w_data_rd[23:0];
                    n_state          = S_DONE;
                end else begin
                    n_lo  = w_nlo;
                    n_hi  = w_nhi;
                    n_mid = w_nmid;
                    if (!(w_nlo < w_nhi)) begin
                        n_res          = '0;
                        n_res.position = sts_pkg::t_pos'(w_nlo);
                        n_state        = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_count     = r_count;

endmodule

### tb/sts_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// sts_checker
// Watches both channels of the table search block, keeps its own copy of the
// table, works out the result of every accepted input transaction and
// compares each accepted result transaction with the oldest one waiting.
// ============================================================================
module sts_checker
    import sts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending,
    output int   o_results,
    output int   o_searches,
    output int   o_hits,
    output int   o_overflows
);

    logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
    logic [DATA_W-1:0] data_mem [TABLE_DEPTH];
    int unsigned       entry_total = 0;
    t_out              expected_results [$];
    t_out              oldest;

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_results   = 0;
        o_searches  = 0;
        o_hits      = 0;
        o_overflows = 0;
    end

    function automatic t_out table_response(input t_in item);
        t_out             r;
        logic [KEY_W-1:0] key;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        bit               done;
        r    = '0;
        key  = {item.type_id, item.resource_id};
        done = 1'b0;
        case (item.func)
            FUNC_LOAD: begin
                r.position = t_pos'(entry_total);
                if (entry_total >= TABLE_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    key_mem[entry_total]  = key;
                    data_mem[entry_total] = {item.data_offset, item.data_length};
                    entry_total++;
                end
            end
            FUNC_CLEAR: begin
                entry_total = 0;
            end
            FUNC_SEARCH: begin
                lo = 0;
                hi = (entry_total > TABLE_DEPTH) ? TABLE_DEPTH : entry_total;
                while (!done && lo < hi) begin
                    mid = (lo + hi) >> 1;
                    if (key < key_mem[mid]) begin
                        hi = mid;
                    end else if (key > key_mem[mid]) begin
                        lo = mid + 1;
                    end else begin
                        r.found      = 1'b1;
                        r.position   = t_pos'(mid);
                        r.hit_offset = data_mem[mid][47:24];
                        r.hit_length = data_mem[mid][23:0];
                        done         = 1'b1;
                    end
                end
                if (!done) begin
                    r.position = t_pos'(lo);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (i_out_data.found === 1'b1) o_hits++;
                if (i_out_data.overflow === 1'b1) o_overflows++;
                if (expected_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("%0t: result with nothing pending: %p", $realtime, i_out_data);
                    end
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_out_data.found !== oldest.found
                            || i_out_data.position !== oldest.position
                            || i_out_data.hit_offset !== oldest.hit_offset
                            || i_out_data.hit_length !== oldest.hit_length
                            || i_out_data.overflow !== oldest.overflow) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("%0t: mismatch", $realtime);
                            $display("  expected found=%0b pos=%0d off=%h len=%h ovf=%0b",
                                     oldest.found, oldest.position, oldest.hit_offset,
                                     oldest.hit_length, oldest.overflow);
                            $display("  actual   found=%0b pos=%0d off=%h len=%h ovf=%0b",
                                     i_out_data.found, i_out_data.position,
                                     i_out_data.hit_offset, i_out_data.hit_length,
                                     i_out_data.overflow);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.func == FUNC_SEARCH) o_searches++;
                expected_results.push_back(table_response(i_in_data));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### tb/tb_sorted_table_binary_search_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_sorted_table_binary_search_top
// Drives load, clear, search and unused-code transactions into the table search block:
// a directed pass over key extremes and corner cases, then mostly sorted
// table builds followed by searches, with noise and out-of-order loads.
// Both channels idle at random.
// ============================================================================
module tb_sorted_table_binary_search_top;
    import sts_pkg::*;

    localparam logic [1:0]       FUNC_UNUSED  = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX      = '1;
    localparam int               RANDOM_ITEMS = 620;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    int errors;
    int pending;
    int results;
    int searches;
    int hits;
    int overflows;

    bit               quiet = 1'b0;
    int               stall_left = 0;
    int               run_left = 0;
    logic             stall_next;
    int               sent_total = 0;
    int               peak_fill = 0;
    logic [KEY_W-1:0] held_keys [$];

    always #1 i_clk = ~i_clk;

    sorted_table_binary_search_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    sts_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_searches  (searches),
        .o_hits      (hits),
        .o_overflows (overflows)
    );

    // mostly short gaps, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
        end else if (run_left > 0) begin
            run_left--;
            stall_next = 1'b0;
        end else begin
            run_left   = $urandom_range(0, 24);
            stall_left = gap_length();
            stall_next = (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
        i_out_stall <= quiet ? 1'b0 : stall_next;
    end

    task automatic issue_full(input logic [1:0] func, input logic [KEY_W-1:0] key,
                              input logic [23:0] off, input logic [23:0] len);
        t_in item;
        int  gap;
        bit  stalled;
        item.func        = func;
        item.type_id     = key[23:16];
        item.resource_id = key[15:0];
        item.data_offset = off;
        item.data_length = len;
        gap = quiet ? 0 : gap_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        sent_total++;
        if (func == FUNC_LOAD && held_keys.size() < TABLE_DEPTH) held_keys.push_back(key);
        if (func == FUNC_CLEAR) held_keys.delete();
        if (held_keys.size() > peak_fill) peak_fill = held_keys.size();
    endtask

    task automatic issue(input logic [1:0] func, input logic [KEY_W-1:0] key);
        issue_full(func, key, 24'($urandom), 24'($urandom));
    endtask

    // hold the sender off until every transaction has its result
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_probe();
        int               r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (held_keys.size() > 0 && r < 45) begin
            k = held_keys[$urandom_range(0, held_keys.size() - 1)];
        end else if (held_keys.size() > 0 && r < 70) begin
            k = held_keys[$urandom_range(0, held_keys.size() - 1)];
            k = $urandom_range(0, 1) ? k + 1'b1 : k - 1'b1;
        end else if (r < 80) begin
            k = $urandom_range(0, 1) ? '0 : KEY_MAX;
        end else begin
            k = KEY_W'($urandom);
        end
        return k;
    endfunction

    // ascending keys spread over the key space, or packed close together
    task automatic load_sorted(input int n, input bit dense);
        longint prev;
        longint span;
        int     i;
        prev = -1;
        if (dense) prev = longint'($urandom_range(0, KEY_MAX - 5 * n - 1)) - 1;
        for (i = 0; i < n; i++) begin
            span = (longint'(KEY_MAX) - prev) / (n - i + 1);
            if (dense && span > 4) span = 4;
            prev = prev + 1 + $urandom_range(0, int'(span));
            issue(FUNC_LOAD, prev[KEY_W-1:0]);
        end
    endtask

    initial begin
        int start;
        int r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, unused code, key extremes, hits and misses
        issue_full(FUNC_SEARCH, '0, '0, '0);
        issue_full(FUNC_UNUSED, KEY_MAX, '1, '1);
        issue_full(FUNC_LOAD, 24'h000000, 24'h000000, 24'hFFFFFF);
        issue_full(FUNC_LOAD, 24'h00FFFF, 24'hFFFFFF, 24'h000000);
        issue_full(FUNC_LOAD, 24'h010000, 24'h555555, 24'hAAAAAA);
        issue_full(FUNC_LOAD, 24'h7F8000, 24'hAAAAAA, 24'h555555);
        issue_full(FUNC_LOAD, KEY_MAX, 24'hFFFFFF, 24'hFFFFFF);
        issue_full(FUNC_SEARCH, 24'h000000, '1, '1);
        issue_full(FUNC_SEARCH, 24'h00FFFF, '1, '1);
        issue_full(FUNC_SEARCH, 24'h010000, '1, '1);
        issue_full(FUNC_SEARCH, 24'h7F8000, '1, '1);
        issue_full(FUNC_SEARCH, KEY_MAX, '1, '1);
        issue_full(FUNC_SEARCH, 24'h000001, '0, '0);
        issue_full(FUNC_SEARCH, 24'h7F7FFF, '0, '0);
        issue_full(FUNC_SEARCH, 24'hFFFFFE, '0, '0);
        issue_full(FUNC_UNUSED, '0, '0, '0);
        issue_full(FUNC_SEARCH, 24'h7F8000, '0, '0);
        // out of order load
        issue_full(FUNC_LOAD, 24'h000005, 24'h123456, 24'h654321);
        issue_full(FUNC_SEARCH, 24'h000005, '0, '0);
        issue_full(FUNC_SEARCH, 24'h7F8000, '0, '0);
        issue_full(FUNC_CLEAR, KEY_MAX, '1, '1);
        issue_full(FUNC_SEARCH, KEY_MAX, '0, '0);
        issue_full(FUNC_LOAD, 24'hABCDEF, 24'hFEDCBA, 24'h0F0F0F);
        issue_full(FUNC_SEARCH, 24'hABCDEF, '0, '0);
        drain();

        start = sent_total;
        while (sent_total - start < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 65) begin
                issue(FUNC_CLEAR, KEY_W'($urandom));
                load_sorted(($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                        : $urandom_range(0, 24),
                            $urandom_range(0, 3) == 0);
                repeat ($urandom_range(4, 16)) issue(FUNC_SEARCH, pick_probe());
            end else if (r < 85) begin
                repeat ($urandom_range(3, 12)) issue(2'($urandom), KEY_W'($urandom));
            end else begin
                issue(FUNC_CLEAR, KEY_W'($urandom));
                load_sorted($urandom_range(1, 16), 1'b0);
                repeat ($urandom_range(1, 3)) issue(FUNC_LOAD, KEY_W'($urandom));
                repeat ($urandom_range(4, 12)) issue(FUNC_SEARCH, pick_probe());
            end
            if ($urandom_range(0, 9) == 0) drain();
        end

        quiet = 1'b0;
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);

        $display("sent %0d transactions, %0d results: %0d searches, %0d hits, %0d dropped loads",
                 sent_total, results, searches, hits, overflows);
        $display("largest table held %0d entries", peak_fill);
        if (errors == 0 && pending == 0) begin
            $display("tb_sorted_table_binary_search_top passed");
        end else begin
            $display("tb_sorted_table_binary_search_top failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_sorted_table_binary_search_top failed");
        $finish;
    end

endmodule
